// File: hw/rtl/cmg_pkg.sv
// Package with shared types, constants and the sine function of the cylinder mesh generator.
package cmg_pkg;

    localparam int MAX_SLICES_DEF = 64;
    localparam int MAX_STACKS_DEF = 64;
    localparam int PHASE_BITS_DEF = 12;

    localparam int CNT_W = 7;
    localparam int GEO_W = 16;
    localparam int POS_W = 17;
    localparam int IDX_W = 13;
    localparam int DIV_W = 24;

    localparam logic [2:0] CFG_BOTTOM = 3'd0;
    localparam logic [2:0] CFG_TOP    = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_SLICES = 3'd3;
    localparam logic [2:0] CFG_STACKS = 3'd4;

    typedef enum logic [2:0] {
        SEC_SIDE_V   = 3'd0,
        SEC_SIDE_T   = 3'd1,
        SEC_TOP_V    = 3'd2,
        SEC_TOP_C    = 3'd3,
        SEC_TOP_T    = 3'd4,
        SEC_BOT_V    = 3'd5,
        SEC_BOT_C    = 3'd6,
        SEC_BOT_T    = 3'd7
    } section_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       start;      // load operands and begin the divisions
        logic       step;       // one divider iteration
        logic       finish;     // form the result word
        section_t   section;
        logic [CNT_W-1:0] ring;
        logic [CNT_W-1:0] slice;
        logic       quad_half;
        logic       last;
    } cmg_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_c;
        logic             is_triangle;
        logic             mesh_last;
    } cmg_rec_t;

    // Quarter-wave sine in Q14, f in 0..16384.
    function automatic logic [14:0] sin_quarter(input logic [14:0] f);
        logic [63:0] x, u, t;
        begin
            x = 64'(f);
            u = (x * x) >> 4;
            t = 64'd2692;
            t = 64'd78547 - ((t * u) >> 24);
            t = 64'd1337020 - ((t * u) >> 24);
            t = 64'd10837479 - ((t * u) >> 24);
            t = 64'd26353589 - ((t * u) >> 24);
            t = (t * x) >> 24;
            if (t > 64'd16384) t = 64'd16384;
            sin_quarter = t[14:0];
        end
    endfunction

endpackage

// File: hw/rtl/cmg_sine_rom.sv
// Registered sine lookup over 16-bit phase, built from a quarter-wave table.
module cmg_sine_rom
    import cmg_pkg::*;
(
    input  logic        aclk,
    input  logic [15:0] phase,
    output logic signed [15:0] sin_reg
);
    logic [14:0] table_q [0:16384];
    logic [1:0]  quad;
    logic [14:0] frac;
    logic [14:0] mag_reg;
    logic        neg_reg;

    // The table is a constant ROM read through a registered port; the magnitude and sign
    // are registered first, and the signed value is then registered from them.
    initial begin
        for (int k = 0; k <= 16384; k++) begin
            table_q[k] = sin_quarter(15'(k));
        end
    end

    assign quad = phase[15:14];
    assign frac = quad[0] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};

    always_ff @(posedge aclk) begin
        mag_reg <= table_q[frac];
        neg_reg <= quad[1];
        sin_reg <= neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end
endmodule

// File: hw/rtl/cmg_datapath.sv
// Datapath: ring y and radius divisions, phase division, sine lookup and record assembly.
module cmg_datapath
    import cmg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic             aclk,
    input  cmg_cmd_t         cmd,
    input  logic [GEO_W-1:0] bottom_radius,
    input  logic [GEO_W-1:0] top_radius,
    input  logic [GEO_W-1:0] cyl_height,
    input  logic [CNT_W:0]   slices,
    input  logic [CNT_W:0]   stacks,
    output cmg_rec_t         rec_reg
);
    localparam int QW = DIV_W;

    // Three restoring dividers share one step counter in the controller.
    logic [QW-1:0] ny_reg, nr_reg, np_reg;
    logic [QW-1:0] qy_reg, qr_reg, qp_reg;
    logic [QW:0]   ry_reg, rr_reg, rp_reg;
    logic          rneg_reg;
    logic [QW:0]   ry_try, rr_try, rp_try;
    logic [15:0]   phase16;
    logic [15:0]   cos_ph;
    logic signed [15:0] sin_v, cos_v;
    logic [GEO_W-1:0]   rad_sel;
    logic signed [POS_W:0] ysel;
    logic [16:0]   diff_mag;
    logic [QW-1:0] ring_rad;
    logic [IDX_W:0] rv, ib0, ib1, side_v, top_ctr, bot_base, bot_ctr;
    logic [PHASE_BITS-1:0] ph_w;
    logic signed [33:0] px, pz;
    cmg_rec_t      rec_next;

    assign ry_try = {ry_reg[QW-1:0], ny_reg[QW-1]} - {{(QW+1-CNT_W-1){1'b0}}, stacks};
    assign rr_try = {rr_reg[QW-1:0], nr_reg[QW-1]} - {{(QW+1-CNT_W-1){1'b0}}, stacks};
    assign rp_try = {rp_reg[QW-1:0], np_reg[QW-1]} - {{(QW+1-CNT_W-1){1'b0}}, slices};

    assign diff_mag = (top_radius >= bottom_radius) ? 17'(top_radius - bottom_radius)
                                                    : 17'(bottom_radius - top_radius);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ny_reg   <= QW'(cmd.ring) * QW'(cyl_height);
            nr_reg   <= QW'(cmd.ring) * QW'(diff_mag);
            np_reg   <= QW'({cmd.slice, {PHASE_BITS{1'b0}}});
            rneg_reg <= (top_radius < bottom_radius);
            ry_reg   <= '0;
            rr_reg   <= '0;
            rp_reg   <= '0;
            qy_reg   <= '0;
            qr_reg   <= '0;
            qp_reg   <= '0;
        end else if (cmd.step) begin
            ny_reg <= {ny_reg[QW-2:0], 1'b0};
            nr_reg <= {nr_reg[QW-2:0], 1'b0};
            np_reg <= {np_reg[QW-2:0], 1'b0};
            if (!ry_try[QW]) ry_reg <= ry_try;
            else ry_reg <= {ry_reg[QW-1:0], ny_reg[QW-1]};
            if (!rr_try[QW]) rr_reg <= rr_try;
            else rr_reg <= {rr_reg[QW-1:0], nr_reg[QW-1]};
            if (!rp_try[QW]) rp_reg <= rp_try;
            else rp_reg <= {rp_reg[QW-1:0], np_reg[QW-1]};
            qy_reg <= {qy_reg[QW-2:0], ~ry_try[QW]};
            qr_reg <= {qr_reg[QW-2:0], ~rr_try[QW]};
            qp_reg <= {qp_reg[QW-2:0], ~rp_try[QW]};
        end
    end

    assign ph_w    = qp_reg[PHASE_BITS-1:0];
    assign phase16 = 16'({ph_w, {(16-PHASE_BITS){1'b0}}});
    assign cos_ph  = phase16 + 16'd16384;

    cmg_sine_rom u_sin (.aclk(aclk), .phase(phase16), .sin_reg(sin_v));
    cmg_sine_rom u_cos (.aclk(aclk), .phase(cos_ph),  .sin_reg(cos_v));

    assign ring_rad = rneg_reg ? QW'(bottom_radius) - qr_reg : QW'(bottom_radius) + qr_reg;

    always_comb begin
        unique case (cmd.section)
            SEC_SIDE_V: rad_sel = ring_rad[GEO_W-1:0];
            SEC_TOP_V:  rad_sel = top_radius;
            SEC_BOT_V:  rad_sel = bottom_radius;
            default:    rad_sel = '0;
        endcase
        unique case (cmd.section)
            SEC_SIDE_V: ysel = $signed({1'b0, qy_reg[POS_W-1:0]})
                               - $signed({2'b0, cyl_height[GEO_W-1:1]});
            SEC_TOP_V, SEC_TOP_C: ysel = $signed({2'b0, cyl_height})
                               - $signed({2'b0, cyl_height[GEO_W-1:1]});
            default:    ysel = -$signed({2'b0, cyl_height[GEO_W-1:1]});
        endcase
    end

    // Signed scale that rounds toward minus infinity.
    function automatic logic [POS_W-1:0] scale(input logic [GEO_W-1:0] r,
                                               input logic signed [15:0] t);
        logic signed [33:0] v;
        logic [33:0] m;
        begin
            v = $signed({18'b0, r}) * 34'(t);
            if (v >= 0) scale = POS_W'(v >>> 14);
            else begin
                m = 34'((-v + 34'sd16383) >> 14);
                scale = POS_W'(-$signed(m));
            end
        end
    endfunction

    assign rv       = (IDX_W+1)'(slices) + 1'b1;
    assign side_v   = (IDX_W+1)'((stacks + 1'b1) * rv);
    assign top_ctr  = side_v + rv;
    assign bot_base = top_ctr + 1'b1;
    assign bot_ctr  = bot_base + rv;
    assign ib0      = (IDX_W+1)'(cmd.ring * rv) + (IDX_W+1)'(cmd.slice);
    assign ib1      = ib0 + rv;
    assign px = '0;
    assign pz = '0;

    always_comb begin
        rec_next = '0;
        unique case (cmd.section)
            SEC_SIDE_V, SEC_TOP_V, SEC_BOT_V, SEC_TOP_C, SEC_BOT_C: begin
                rec_next.pos_y = POS_W'(ysel);
                if (cmd.section != SEC_TOP_C && cmd.section != SEC_BOT_C) begin
                    rec_next.pos_x = scale(rad_sel, cos_v) | POS_W'(px);
                    rec_next.pos_z = scale(rad_sel, sin_v) | POS_W'(pz);
                end
            end
            SEC_SIDE_T: begin
                rec_next.is_triangle = 1'b1;
                rec_next.index_a = ib0[IDX_W-1:0];
                if (!cmd.quad_half) begin
                    rec_next.index_b = ib1[IDX_W-1:0];
                    rec_next.index_c = IDX_W'(ib1 + 1'b1);
                end else begin
                    rec_next.index_b = IDX_W'(ib1 + 1'b1);
                    rec_next.index_c = IDX_W'(ib0 + 1'b1);
                end
            end
            SEC_TOP_T: begin
                rec_next.is_triangle = 1'b1;
                rec_next.index_a = top_ctr[IDX_W-1:0];
                rec_next.index_b = IDX_W'(side_v + cmd.slice + 1'b1);
                rec_next.index_c = IDX_W'(side_v + cmd.slice);
            end
            SEC_BOT_T: begin
                rec_next.is_triangle = 1'b1;
                rec_next.index_a = bot_ctr[IDX_W-1:0];
                rec_next.index_b = IDX_W'(bot_base + cmd.slice);
                rec_next.index_c = IDX_W'(bot_base + cmd.slice + 1'b1);
                rec_next.mesh_last = cmd.last;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) rec_reg <= rec_next;
    end
endmodule

// File: hw/rtl/cmg_ctrl.sv
// Controller: walk counters, handshakes and sequencing of the datapath.
module cmg_ctrl
    import cmg_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           restart,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  logic           cfg_write,
    input  logic [CNT_W:0] slices,
    input  logic [CNT_W:0] stacks,
    output cmg_cmd_t       cmd
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_LOOK, ST_OUT} state_t;

    // Cycles the sine lookup needs after the last divider step.
    localparam logic [4:0] LOOK_WAIT = 5'd2;

    state_t           state_reg, state_next;
    section_t         sec_reg, sec_next;
    logic [CNT_W-1:0] ring_reg, ring_next, slice_reg, slice_next;
    logic             half_reg, half_next, out_valid_reg, out_valid_next;
    logic [4:0]       step_reg, step_next;
    cmg_cmd_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0] ring_w, slice_w;
    section_t         sec_w;
    logic             half_w, last_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign cmd      = cmd_reg;

    // The item being worked on uses the latched counters; restart zeroes them.
    always_comb begin
        sec_w   = restart ? SEC_SIDE_V : sec_reg;
        ring_w  = restart ? '0 : ring_reg;
        slice_w = restart ? '0 : slice_reg;
        half_w  = restart ? 1'b0 : half_reg;
    end

    assign last_w = ({1'b0, cmd_reg.slice} + 1'b1 >= slices);

    always_comb begin
        state_next = state_reg;
        sec_next = sec_reg;
        ring_next = ring_reg;
        slice_next = slice_reg;
        half_next = half_reg;
        out_valid_next = out_valid_reg;
        step_next = step_reg;
        cmd_next = cmd_reg;
        cmd_next.start = 1'b0;
        cmd_next.step = 1'b0;
        cmd_next.finish = 1'b0;
        if (m_tvalid && m_tready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                cmd_next.start = 1'b1; cmd_next.section = sec_w; cmd_next.ring = ring_w;
                cmd_next.slice = slice_w; cmd_next.quad_half = half_w;
                step_next = 5'(DIV_W); state_next = ST_DIV;
                sec_next = sec_w; ring_next = ring_w; slice_next = slice_w; half_next = half_w;
                // Advance the walk counters.
                unique case (sec_w)
                    SEC_SIDE_V: if ({1'b0, slice_w} + 1'b1 > slices) begin
                        slice_next = '0;
                        if ({1'b0, ring_w} + 1'b1 > stacks) begin
                            ring_next = '0; sec_next = SEC_SIDE_T;
                        end else ring_next = ring_w + 1'b1;
                    end else begin
                        slice_next = slice_w + 1'b1;
                    end
                    SEC_SIDE_T: begin
                        half_next = ~half_w;
                        if (half_w) begin
                            if ({1'b0, slice_w} + 1'b1 >= slices) begin
                                slice_next = '0;
                                if ({1'b0, ring_w} + 1'b1 >= stacks) begin
                                    ring_next = '0; sec_next = SEC_TOP_V;
                                end else ring_next = ring_w + 1'b1;
                            end else slice_next = slice_w + 1'b1;
                        end
                    end
                    SEC_TOP_V, SEC_BOT_V: begin
                        if ({1'b0, slice_w} + 1'b1 > slices) begin
                            slice_next = '0;
                            sec_next = (sec_w == SEC_TOP_V) ? SEC_TOP_C : SEC_BOT_C;
                        end else begin
                            slice_next = slice_w + 1'b1;
                        end
                    end
                    SEC_TOP_C, SEC_BOT_C: begin
                        slice_next = '0;
                        sec_next = (sec_w == SEC_TOP_C) ? SEC_TOP_T : SEC_BOT_T;
                    end
                    SEC_TOP_T: begin
                        if ({1'b0, slice_w} + 1'b1 >= slices) begin
                            slice_next = '0; sec_next = SEC_BOT_V;
                        end else begin
                            slice_next = slice_w + 1'b1;
                        end
                    end
                    SEC_BOT_T: begin
                        if ({1'b0, slice_w} + 1'b1 >= slices) begin
                            sec_next = SEC_SIDE_V; ring_next = '0; slice_next = '0;
                            half_next = 1'b0;
                        end else begin
                            slice_next = slice_w + 1'b1;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                cmd_next.step = 1'b1;
                step_next = step_reg - 1'b1;
                if (step_reg == 5'd1) begin
                    state_next = ST_LOOK;
                    step_next = LOOK_WAIT;
                end
            end
            ST_LOOK: if (step_reg != '0) begin
                step_next = step_reg - 1'b1;
            end else if (!out_valid_reg || m_tready) begin
                cmd_next.finish = 1'b1; cmd_next.last = last_w; state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid_next = 1'b1; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_write) begin
            sec_next = SEC_SIDE_V; ring_next = '0; slice_next = '0; half_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; sec_reg <= SEC_SIDE_V; ring_reg <= '0;
            slice_reg <= '0; half_reg <= 1'b0; out_valid_reg <= 1'b0;
            step_reg <= '0; cmd_reg <= '0;
        end else begin
            state_reg <= state_next; sec_reg <= sec_next; ring_reg <= ring_next;
            slice_reg <= slice_next; half_reg <= half_next; out_valid_reg <= out_valid_next;
            step_reg <= step_next; cmd_reg <= cmd_next;
        end
    end
endmodule

// File: hw/rtl/cylinder_mesh_generator.sv
// Top level of the cylinder mesh generator: configuration registers, controller and datapath.
//
// Each word accepted on the s_ channel (tdata bit 0 = restart) produces one mesh record
// on the m_ channel: side ring vertices, side triangles, the top cap ring, centre and fan,
// then the bottom cap ring, centre and fan; the walk wraps after the last bottom triangle,
// which carries m_tlast. m_tuser is 1 for a triangle record and 0 for a vertex.
// Configuration registers are written over cfg_valid/cfg_ready with cfg_index/cfg_data;
// any register write restarts the walk. Writes are taken in every cycle.
// From acceptance to m_tvalid a word passes through a 24-step restoring division (ring y,
// ring radius and slice phase in parallel), then the sine lookup and the result register.
// A new word is taken once the previous result is registered, not while a word is still
// in the division or the lookup.
// The result stays in its register while m_tready is low; the next word's work runs
// meanwhile and waits for the register to free up. Reset (aresetn low, synchronous)
// restores the default geometry and starts the walk at the first side vertex.
module cylinder_mesh_generator
    import cmg_pkg::*;
#(
    parameter int MAX_SLICES = MAX_SLICES_DEF,
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pos_x, pos_y, pos_z, index_a, index_b, index_c
    output logic        m_tuser,   // is_triangle
    output logic        m_tlast    // mesh_last
);
    logic [GEO_W-1:0] bottom_reg, top_reg, height_reg;
    logic [CNT_W-1:0] slice_cnt_reg, stack_cnt_reg;
    logic [CNT_W:0]   slices, stacks;
    logic             cfg_write;
    cmg_cmd_t         cmd;
    cmg_rec_t         rec;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready && (cfg_index <= CFG_STACKS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bottom_reg <= 16'd256; top_reg <= 16'd256; height_reg <= 16'd512;
            slice_cnt_reg <= 7'd16; stack_cnt_reg <= 7'd4;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BOTTOM: bottom_reg <= cfg_data;
                CFG_TOP:    top_reg <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_SLICES: slice_cnt_reg <= cfg_data[CNT_W-1:0];
                CFG_STACKS: stack_cnt_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        slices = (slice_cnt_reg == '0) ? (CNT_W+1)'(1) : (CNT_W+1)'(slice_cnt_reg);
        if (32'(slices) > MAX_SLICES) slices = (CNT_W+1)'(MAX_SLICES);
        stacks = (stack_cnt_reg == '0) ? (CNT_W+1)'(1) : (CNT_W+1)'(stack_cnt_reg);
        if (32'(stacks) > MAX_STACKS) stacks = (CNT_W+1)'(MAX_STACKS);
    end

    cmg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .restart(s_tdata[0]), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_write(cfg_write), .slices(slices), .stacks(stacks), .cmd(cmd)
    );

    cmg_datapath #(.PHASE_BITS(PHASE_BITS)) u_dp (
        .aclk(aclk), .cmd(cmd), .bottom_radius(bottom_reg),
        .top_radius(top_reg), .cyl_height(height_reg), .slices(slices),
        .stacks(stacks), .rec_reg(rec)
    );

    assign m_tdata = {6'b0, rec.index_c, rec.index_b, rec.index_a,
                      rec.pos_z, rec.pos_y, rec.pos_x};
    assign m_tuser = rec.is_triangle;
    assign m_tlast = rec.mesh_last;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted word while busy");
    a_last_tri: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser) else $error("tlast on a vertex record");
    a_no_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_tvalid)
        else $error("result overwritten while stalled");
endmodule

// File: bench/testbench.sv
// Testbench for the cylinder mesh generator: random words and settings checked by a scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cmg_pkg::*;

    typedef struct {
        bit          is_tri;
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [12:0] a;
        logic [12:0] b;
        logic [12:0] c;
        bit          last;
    } mesh_rec_t;

    class mesh_scoreboard;
        logic [15:0] bottom_r, top_r, height;
        logic [6:0]  slices_reg, stacks_reg;
        section_t    sec;
        int          ring, slice;
        bit          half_quad;
        mesh_rec_t   pending[$];
        int          errors, results, triangles, meshes;

        function new();
            bottom_r = 256; top_r = 256; height = 512;
            slices_reg = 16; stacks_reg = 4;
            rewind();
        endfunction

        function void rewind();
            sec = SEC_SIDE_V; ring = 0; slice = 0; half_quad = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_BOTTOM: bottom_r = val;
                CFG_TOP:    top_r = val;
                CFG_HEIGHT: height = val;
                CFG_SLICES: slices_reg = val[6:0];
                CFG_STACKS: stacks_reg = val[6:0];
                default: return;
            endcase
            rewind();
        endfunction

        function int clamp_count(logic [6:0] v);
            if (v == 0) return 1;
            if (v > 64) return 64;
            return int'(v);
        endfunction

        function longint quarter_wave(longint unsigned f);
            longint unsigned u, t;
            u = (f * f) >> 4;
            t = 2692;
            t = 78547 - ((t * u) >> 24);
            t = 1337020 - ((t * u) >> 24);
            t = 10837479 - ((t * u) >> 24);
            t = 26353589 - ((t * u) >> 24);
            t = (t * f) >> 24;
            if (t > 16384) t = 16384;
            return t;
        endfunction

        function longint sine16(int unsigned p);
            int unsigned q, f;
            longint s;
            p = p & 16'hFFFF;
            q = p >> 14;
            f = p & 16'h3FFF;
            if (q[0]) f = 16384 - f;
            s = quarter_wave(f);
            return q[1] ? -s : s;
        endfunction

        // Rounds toward minus infinity, as the hardware's scale function does.
        function longint scale(longint r, longint t);
            longint v;
            v = r * t;
            if (v >= 0) return v >>> 14;
            return -((-v + 16383) >>> 14);
        endfunction

        function mesh_rec_t vertex(longint r, longint y, int j, bit centre);
            mesh_rec_t v;
            int unsigned ph;
            ph = ((j << 12) / clamp_count(slices_reg)) & 12'hFFF;
            ph = ph << 4;
            v = '{default: 0};
            v.y = y[16:0];
            if (!centre) begin
                v.x = 17'(scale(r, sine16(ph + 16384)));
                v.z = 17'(scale(r, sine16(ph)));
            end
            return v;
        endfunction

        function mesh_rec_t triangle(int a, int b, int c, bit last);
            mesh_rec_t v;
            v = '{default: 0};
            v.is_tri = 1; v.a = 13'(a); v.b = 13'(b); v.c = 13'(c); v.last = last;
            return v;
        endfunction

        function void note_word(bit restart);
            int sl, st, rv, side_v, top_base, top_ctr, bot_base, bot_ctr, i, j;
            longint half, y_top, num, q, y;
            mesh_rec_t r;
            sl = clamp_count(slices_reg);
            st = clamp_count(stacks_reg);
            rv = sl + 1;
            side_v = (st + 1) * rv;
            top_base = side_v; top_ctr = side_v + rv;
            bot_base = top_ctr + 1; bot_ctr = bot_base + rv;
            half = longint'(height >> 1);
            y_top = longint'(height) - half;
            if (restart) rewind();
            i = ring; j = slice;
            case (sec)
                SEC_SIDE_V: begin
                    y = (longint'(i) * height) / st - half;
                    num = longint'(i) * (longint'(top_r) - longint'(bottom_r));
                    q = (num < 0 ? -num : num) / st;
                    r = vertex(longint'(bottom_r) + (num < 0 ? -q : q), y, j, 0);
                    slice++;
                    if (slice > sl) begin
                        slice = 0; ring++;
                        if (ring > st) begin ring = 0; sec = SEC_SIDE_T; end
                    end
                end
                SEC_SIDE_T: begin
                    if (!half_quad)
                        r = triangle(i * rv + j, (i + 1) * rv + j, (i + 1) * rv + j + 1, 0);
                    else
                        r = triangle(i * rv + j, (i + 1) * rv + j + 1, i * rv + j + 1, 0);
                    half_quad ^= 1;
                    if (!half_quad) begin
                        slice++;
                        if (slice >= sl) begin
                            slice = 0; ring++;
                            if (ring >= st) begin ring = 0; sec = SEC_TOP_V; end
                        end
                    end
                end
                SEC_TOP_V: begin
                    r = vertex(longint'(top_r), y_top, j, 0);
                    slice++;
                    if (slice > sl) begin slice = 0; sec = SEC_TOP_C; end
                end
                SEC_TOP_C: begin
                    r = vertex(0, y_top, 0, 1);
                    slice = 0; sec = SEC_TOP_T;
                end
                SEC_TOP_T: begin
                    r = triangle(top_ctr, top_base + j + 1, top_base + j, 0);
                    slice++;
                    if (slice >= sl) begin slice = 0; sec = SEC_BOT_V; end
                end
                SEC_BOT_V: begin
                    r = vertex(longint'(bottom_r), -half, j, 0);
                    slice++;
                    if (slice > sl) begin slice = 0; sec = SEC_BOT_C; end
                end
                SEC_BOT_C: begin
                    r = vertex(0, -half, 0, 1);
                    slice = 0; sec = SEC_BOT_T;
                end
                default: begin
                    r = triangle(bot_ctr, bot_base + j, bot_base + j + 1, j + 1 >= sl);
                    if (j + 1 >= sl) rewind();
                    else slice++;
                end
            endcase
            pending = {pending, r};
        endfunction

        function void check(mesh_rec_t got);
            mesh_rec_t exp_r;
            results++;
            if (pending.size() == 0) begin
                $error("record arrived with nothing expected");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.is_tri) triangles++;
            if (got.last) meshes++;
            if (got.is_tri !== exp_r.is_tri) begin
                $error("is_triangle: expected %0d, got %0d", exp_r.is_tri, got.is_tri);
                errors++;
            end
            if (got.x !== exp_r.x) begin
                $error("pos_x: expected %0d, got %0d", $signed(exp_r.x), $signed(got.x));
                errors++;
            end
            if (got.y !== exp_r.y) begin
                $error("pos_y: expected %0d, got %0d", $signed(exp_r.y), $signed(got.y));
                errors++;
            end
            if (got.z !== exp_r.z) begin
                $error("pos_z: expected %0d, got %0d", $signed(exp_r.z), $signed(got.z));
                errors++;
            end
            if (got.a !== exp_r.a) begin
                $error("index_a: expected %0d, got %0d", exp_r.a, got.a);
                errors++;
            end
            if (got.b !== exp_r.b) begin
                $error("index_b: expected %0d, got %0d", exp_r.b, got.b);
                errors++;
            end
            if (got.c !== exp_r.c) begin
                $error("index_c: expected %0d, got %0d", exp_r.c, got.c);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("mesh_last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    mesh_scoreboard mesh_sb;
    int  hold_cycles;
    bit  no_idle;
    int  stall_left;
    int  words_sent;
    longint cycle_count;

    cylinder_mesh_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: check every accepted word, then choose the next ready value.
    initial begin
        mesh_rec_t got;
        stall_left = 0;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.is_tri = m_tuser;
                got.x = m_tdata[16:0];
                got.y = m_tdata[33:17];
                got.z = m_tdata[50:34];
                got.a = m_tdata[63:51];
                got.b = m_tdata[76:64];
                got.c = m_tdata[89:77];
                got.last = m_tlast;
                mesh_sb.check(got);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else begin
                stall_left = idle_len();
                m_tready <= (stall_left == 0);
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic send_word(bit restart);
        int gap;
        s_tvalid <= 1;
        s_tdata <= {7'($urandom()), restart};
        do @(posedge aclk); while (!s_tready);
        mesh_sb.note_word(restart);
        words_sent++;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (mesh_sb.pending.size() != 0) @(posedge aclk);
        // Every accepted word has been checked by the time the queue is empty.
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        mesh_sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(logic [15:0] br, logic [15:0] tr, logic [15:0] h,
                                logic [6:0] sl, logic [6:0] st);
        drain();
        write_reg(CFG_BOTTOM, br);
        write_reg(CFG_TOP, tr);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_SLICES, {9'($urandom()), sl});
        write_reg(CFG_STACKS, {9'($urandom()), st});
    endtask

    task automatic run_words(int n, int restart_odds);
        repeat (n) send_word($urandom_range(1, restart_odds) == 1);
    endtask

    initial begin
        mesh_sb = new();
        hold_cycles = 0;
        no_idle = 0;
        words_sent = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        cfg_valid = 0;
        cfg_index = CFG_BOTTOM;
        cfg_data = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Default geometry, with restarts early and mid ring.
        send_word(1);
        repeat (6) send_word(0);
        send_word(1);
        repeat (10) send_word(0);

        // Smallest mesh at zero and full radius and full height, walked through twice.
        set_geometry(16'd0, 16'hFFFF, 16'hFFFF, 7'd1, 7'd1);
        repeat (30) send_word(0);
        set_geometry(16'hFFFF, 16'd0, 16'd0, 7'd2, 7'd1);
        run_words(60, 50);
        // Zero counts act as one, counts above the maximum as the maximum.
        set_geometry(16'd0, 16'd0, 16'd1, 7'd0, 7'd0);
        run_words(40, 50);
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 7'd65);
        write_reg(3'd6, 16'($urandom()));
        run_words(60, 1000);

        // The receiver holds off while the sender keeps offering words.
        set_geometry(16'd300, 16'd100, 16'd1001, 7'd3, 7'd2);
        hold_cycles = 500;
        run_words(60, 40);
        drain();
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd7, 16'h0000);

        for (int p = 0; p < 14; p++) begin
            set_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()),
                         7'($urandom_range(1, 8)), 7'($urandom_range(1, 4)));
            no_idle = (p % 4 == 1);
            for (int k = 0; k < 80; k++) begin
                send_word($urandom_range(1, 40) == 1);
                if ($urandom_range(1, 60) == 1) begin
                    s_tvalid <= 0;
                    @(posedge aclk);
                    while (mesh_sb.pending.size() != 0) @(posedge aclk);
                end
            end
        end
        no_idle = 0;

        drain();
        $display("Run covered %0d words in %0d records, %0d triangles, %0d complete meshes,",
                 words_sent, mesh_sb.results, mesh_sb.triangles, mesh_sb.meshes);
        $display("over extreme and random radii, heights and slice and stack counts.");
        if (mesh_sb.errors == 0 && mesh_sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
